// ===== rtl/core/lsps_pkg.sv =====
// Shared widths, types and codes for the lit sphere pixel shader.
// No dependencies; used by lsps_isqrt and lit_sphere_pixel_shader_top.
package lsps_pkg;

	// Raster size; positions at or beyond it are background.
	localparam int COLUMNS = 1024;
	localparam int ROWS    = 1024;

	// Field and datapath widths.
	localparam int COORD_W     = 10;
	localparam int CENTRE_W    = 11;
	localparam int OFS_W       = 12;
	localparam int SQ_W        = 22;
	localparam int D2_W        = 23;
	localparam int RAD_SQ_W    = 32;
	localparam int DIR_W       = 16;
	localparam int PACKED_W    = 3 * DIR_W;
	localparam int XY_PROD_W   = OFS_W + DIR_W;
	localparam int XY_SUM_W    = XY_PROD_W + 1;
	localparam int ROOT_W      = 20;
	localparam int RADICAND_W  = 2 * ROOT_W;
	localparam int REM_W       = ROOT_W + 2;
	localparam int SQRT_STAGES = ROOT_W / 2;
	localparam int Z_PROD_W    = ROOT_W + 1 + DIR_W;
	localparam int DOT_W       = Z_PROD_W + 2;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;

	typedef logic signed [XY_SUM_W-1:0] xy_sum_t;

	// Data that travels beside the radicand through the square root pipeline.
	typedef struct packed {
		logic    in_disc;
		xy_sum_t sun_xy;
		xy_sum_t earth_xy;
	} shade_side_t;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_CENTER_X        = 3'd0;
	localparam logic [2:0] REG_CENTER_Y        = 3'd1;
	localparam logic [2:0] REG_RADIUS_SQ       = 3'd2;
	localparam logic [2:0] REG_SUN_DIRECTION   = 3'd3;
	localparam logic [2:0] REG_EARTH_DIRECTION = 3'd4;

	// Shade classes.
	localparam logic [1:0] CLS_BG    = 2'd0;
	localparam logic [1:0] CLS_SUN   = 2'd1;
	localparam logic [1:0] CLS_EARTH = 2'd2;
	localparam logic [1:0] CLS_DARK  = 2'd3;

	// Colours as {red, green, blue}.
	localparam logic [23:0] RGB_BG    = {8'd0, 8'd0, 8'd0};
	localparam logic [23:0] RGB_SUN   = {8'd100, 8'd100, 8'd0};
	localparam logic [23:0] RGB_EARTH = {8'd157, 8'd204, 8'd224};
	localparam logic [23:0] RGB_DARK  = {8'd179, 8'd179, 8'd179};

endpackage

// ===== rtl/core/lit_sphere_pixel_shader_top.sv =====
// Top level of the lit sphere pixel shader: register file, offset, disc and
// dot product stages around the square root pipeline. Depends on lsps_pkg, lsps_isqrt.
//
//  Channel   Direction  Transfer carries
//  s_axis    in         tdata: column[9:0], row[19:10], zero pad [23:20]
//  m_axis    out        tdata: blue[7:0], green[15:8], red[23:16]; tuser: shade_class
//  apb       in/out     64-bit registers at byte address 8*index, pready always high
//
// One pixel is accepted per cycle while the output is not stalled; a result passes
// through four front stages, ten square root stages of two root bits each, and two dot
// product stages. Every stage keeps a valid bit and loads whenever it is empty or
// its successor loads, so bubbles close up and a stalled output holds its result.
// Reset clears the valid bits and loads the register reset values; no sweep is needed.
module lit_sphere_pixel_shader_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Pixel input.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [23:0]                       s_axis_tdata,   // column, row, pad
	// Pixel output.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,   // blue, green, red
	output logic [1:0]                        m_axis_tuser,   // shade_class
	// Configuration.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lsps_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [lsps_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [lsps_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	// Configuration registers.
	logic [lsps_pkg::CENTRE_W-1:0] center_x_q;
	logic [lsps_pkg::CENTRE_W-1:0] center_y_q;
	logic [lsps_pkg::RAD_SQ_W-1:0] radius_sq_q;
	logic [lsps_pkg::PACKED_W-1:0] sun_dir_q;
	logic [lsps_pkg::PACKED_W-1:0] earth_dir_q;
	logic                          cfg_write;
	logic [2:0]                    cfg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_index = paddr[5:3];

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= lsps_pkg::CENTRE_W'(494);
			center_y_q  <= lsps_pkg::CENTRE_W'(370);
			radius_sq_q <= '0;
			sun_dir_q   <= '0;
			earth_dir_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				lsps_pkg::REG_CENTER_X:        center_x_q  <= pwdata[lsps_pkg::CENTRE_W-1:0];
				lsps_pkg::REG_CENTER_Y:        center_y_q  <= pwdata[lsps_pkg::CENTRE_W-1:0];
				lsps_pkg::REG_RADIUS_SQ:       radius_sq_q <= pwdata[lsps_pkg::RAD_SQ_W-1:0];
				lsps_pkg::REG_SUN_DIRECTION:   sun_dir_q   <= pwdata[lsps_pkg::PACKED_W-1:0];
				lsps_pkg::REG_EARTH_DIRECTION: earth_dir_q <= pwdata[lsps_pkg::PACKED_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (cfg_index)
			lsps_pkg::REG_CENTER_X:        prdata = lsps_pkg::CFG_DATA_W'(center_x_q);
			lsps_pkg::REG_CENTER_Y:        prdata = lsps_pkg::CFG_DATA_W'(center_y_q);
			lsps_pkg::REG_RADIUS_SQ:       prdata = lsps_pkg::CFG_DATA_W'(radius_sq_q);
			lsps_pkg::REG_SUN_DIRECTION:   prdata = lsps_pkg::CFG_DATA_W'(sun_dir_q);
			lsps_pkg::REG_EARTH_DIRECTION: prdata = lsps_pkg::CFG_DATA_W'(earth_dir_q);
			default:                       prdata = '0;
		endcase
	end

	// Direction components, Q1.15.
	logic signed [lsps_pkg::DIR_W-1:0] sun_dx, sun_dy, sun_dz;
	logic signed [lsps_pkg::DIR_W-1:0] earth_dx, earth_dy, earth_dz;

	assign sun_dx   = $signed(sun_dir_q[15:0]);
	assign sun_dy   = $signed(sun_dir_q[31:16]);
	assign sun_dz   = $signed(sun_dir_q[47:32]);
	assign earth_dx = $signed(earth_dir_q[15:0]);
	assign earth_dy = $signed(earth_dir_q[31:16]);
	assign earth_dz = $signed(earth_dir_q[47:32]);

	// Stage enables: a stage loads when it is empty or its successor loads.
	logic en1, en2, en3, en4, en5, en6;
	logic sq_in_ready;

	// Stage 1: offsets from the disc centre and the raster check.
	logic [lsps_pkg::COORD_W-1:0]    in_column, in_row;
	logic                            v_s1;
	logic signed [lsps_pkg::OFS_W-1:0] x_s1, y_s1;
	logic                            raster_s1;

	assign in_column     = s_axis_tdata[9:0];
	assign in_row        = s_axis_tdata[19:10];
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			x_s1 <= $signed(lsps_pkg::OFS_W'(in_column) - lsps_pkg::OFS_W'(center_x_q));
			y_s1 <= $signed(lsps_pkg::OFS_W'(center_y_q) - lsps_pkg::OFS_W'(in_row));
			raster_s1 <= (32'(in_column) < 32'(lsps_pkg::COLUMNS))
				&& (32'(in_row) < 32'(lsps_pkg::ROWS));
		end
	end

	// Stage 2: squares and the in-plane products with both directions.
	logic                                  v_s2, raster_s2;
	logic [lsps_pkg::SQ_W-1:0]             xsq_s2, ysq_s2;
	logic signed [lsps_pkg::XY_PROD_W-1:0] sx_s2, sy_s2, ex_s2, ey_s2;
	logic signed [2*lsps_pkg::OFS_W-1:0]   xx_full, yy_full;

	assign en2     = !v_s2 || en3;
	assign xx_full = x_s1 * x_s1;
	assign yy_full = y_s1 * y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			raster_s2 <= raster_s1;
			xsq_s2    <= xx_full[lsps_pkg::SQ_W-1:0];
			ysq_s2    <= yy_full[lsps_pkg::SQ_W-1:0];
			sx_s2     <= x_s1 * sun_dx;
			sy_s2     <= y_s1 * sun_dy;
			ex_s2     <= x_s1 * earth_dx;
			ey_s2     <= y_s1 * earth_dy;
		end
	end

	// Stage 3: squared distance and in-plane partial dot products.
	logic                          v_s3, raster_s3;
	logic [lsps_pkg::D2_W-1:0]     d2_s3;
	lsps_pkg::xy_sum_t             sxy_s3, exy_s3;

	assign en3 = !v_s3 || en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			raster_s3 <= raster_s2;
			d2_s3     <= lsps_pkg::D2_W'(xsq_s2) + lsps_pkg::D2_W'(ysq_s2);
			sxy_s3    <= lsps_pkg::XY_SUM_W'(sx_s2) + lsps_pkg::XY_SUM_W'(sy_s2);
			exy_s3    <= lsps_pkg::XY_SUM_W'(ex_s2) + lsps_pkg::XY_SUM_W'(ey_s2);
		end
	end

	// Stage 4: disc test and the radicand for z.
	logic                              v_s4;
	logic [lsps_pkg::RADICAND_W-1:0]   rad_s4;
	lsps_pkg::shade_side_t             side_s4;
	logic [lsps_pkg::RAD_SQ_W-1:0]     d2s, z_rem;
	logic                              disc_hit;

	assign en4      = !v_s4 || sq_in_ready;
	assign d2s      = lsps_pkg::RAD_SQ_W'({d2_s3, 8'h00});
	assign disc_hit = raster_s3 && (d2s <= radius_sq_q);
	assign z_rem    = radius_sq_q - d2s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			rad_s4           <= disc_hit ? {z_rem, 8'h00} : '0;
			side_s4.in_disc  <= disc_hit;
			side_s4.sun_xy   <= sxy_s3;
			side_s4.earth_xy <= exy_s3;
		end
	end

	// Square root of the radicand gives z with eight fraction bits.
	logic                          sq_out_valid;
	logic [lsps_pkg::ROOT_W-1:0]   sq_root;
	lsps_pkg::shade_side_t         sq_side;

	lsps_isqrt u_isqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s4),
		.in_ready    (sq_in_ready),
		.in_radicand (rad_s4),
		.in_side     (side_s4),
		.out_valid   (sq_out_valid),
		.out_ready   (en5),
		.out_root    (sq_root),
		.out_side    (sq_side)
	);

	// Stage 5: z times the depth component of each direction.
	logic                                 v_s5, inside_s5;
	logic signed [lsps_pkg::Z_PROD_W-1:0] sz_s5, ez_s5;
	lsps_pkg::xy_sum_t                    sxy_s5, exy_s5;
	logic signed [lsps_pkg::ROOT_W:0]     z_signed;

	assign en5      = !v_s5 || en6;
	assign z_signed = $signed({1'b0, sq_root});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= sq_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && sq_out_valid) begin
			inside_s5 <= sq_side.in_disc;
			sxy_s5    <= sq_side.sun_xy;
			exy_s5    <= sq_side.earth_xy;
			sz_s5     <= z_signed * sun_dz;
			ez_s5     <= z_signed * earth_dz;
		end
	end

	// Stage 6: full dot products, their signs, and the output register.
	logic signed [lsps_pkg::DOT_W-1:0] sun_dot, earth_dot;
	logic                              sun_lit, earth_lit;
	logic [1:0]                        shade;
	logic [23:0]                       rgb;

	assign en6       = !m_axis_tvalid || m_axis_tready;
	assign sun_dot   = (lsps_pkg::DOT_W'(sxy_s5) <<< 8) + lsps_pkg::DOT_W'(sz_s5);
	assign earth_dot = (lsps_pkg::DOT_W'(exy_s5) <<< 8) + lsps_pkg::DOT_W'(ez_s5);
	assign sun_lit   = !sun_dot[lsps_pkg::DOT_W-1] && (sun_dot != '0);
	assign earth_lit = !earth_dot[lsps_pkg::DOT_W-1] && (earth_dot != '0);

	// Class and colour; exact zeros fall through to dark.
	always_comb begin
		if (!inside_s5) begin
			shade = lsps_pkg::CLS_BG;
		end else if (sun_lit) begin
			shade = lsps_pkg::CLS_SUN;
		end else if (earth_lit) begin
			shade = lsps_pkg::CLS_EARTH;
		end else begin
			shade = lsps_pkg::CLS_DARK;
		end
		case (shade)
			lsps_pkg::CLS_SUN:   rgb = lsps_pkg::RGB_SUN;
			lsps_pkg::CLS_EARTH: rgb = lsps_pkg::RGB_EARTH;
			lsps_pkg::CLS_DARK:  rgb = lsps_pkg::RGB_DARK;
			default:             rgb = lsps_pkg::RGB_BG;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en6) begin
			m_axis_tvalid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			m_axis_tdata <= {rgb[23:16], rgb[15:8], rgb[7:0]};
			m_axis_tuser <= shade;
		end
	end

`ifndef SYNTHESIS
	// Background results are always black.
	a_bg_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == lsps_pkg::CLS_BG) |-> (m_axis_tdata == 24'd0))
		else $error("background pixel with non-black colour");

	// With the output register empty the whole ready chain is open.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled although output register is empty");

	// A blocked first stage keeps its offsets.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(x_s1) && $stable(y_s1))
		else $error("first stage item changed while stalled");
`endif

endmodule

// ===== rtl/core/lsps_isqrt.sv =====
// Pipelined integer square root, two root bits per stage, with sideband data.
// Depends on lsps_pkg for widths and the sideband struct.
module lsps_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lsps_pkg::RADICAND_W-1:0]     in_radicand,
	input  lsps_pkg::shade_side_t               in_side,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lsps_pkg::ROOT_W-1:0]         out_root,
	output lsps_pkg::shade_side_t               out_side
);

	typedef struct packed {
		logic [lsps_pkg::REM_W-1:0]  rem;
		logic [lsps_pkg::ROOT_W-1:0] root;
	} sq_step_t;

	// One restoring step: bring down two radicand bits and try the next root bit.
	function automatic sq_step_t sqrt_step(input logic [lsps_pkg::REM_W-1:0] rem,
			input logic [lsps_pkg::ROOT_W-1:0] root, input logic [1:0] pair);
		logic [lsps_pkg::REM_W+1:0] r;
		logic [lsps_pkg::REM_W+1:0] t;
		sq_step_t res;
		r = {rem, pair};
		t = (lsps_pkg::REM_W+2)'({root, 2'b01});
		if (r >= t) begin
			res.rem  = lsps_pkg::REM_W'(r - t);
			res.root = {root[lsps_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			res.rem  = lsps_pkg::REM_W'(r);
			res.root = {root[lsps_pkg::ROOT_W-2:0], 1'b0};
		end
		return res;
	endfunction

	localparam int LAST = lsps_pkg::SQRT_STAGES - 1;

	logic [lsps_pkg::SQRT_STAGES-1:0] v_s;
	logic [lsps_pkg::SQRT_STAGES-1:0] en;
	logic [lsps_pkg::REM_W-1:0]       rem_s  [lsps_pkg::SQRT_STAGES];
	logic [lsps_pkg::ROOT_W-1:0]      root_s [lsps_pkg::SQRT_STAGES];
	logic [lsps_pkg::RADICAND_W-1:0]  rad_s  [lsps_pkg::SQRT_STAGES];
	lsps_pkg::shade_side_t            side_s [lsps_pkg::SQRT_STAGES];

	// Each stage resolves two root bits and shifts the radicand on by four bits.
	for (genvar k = 0; k < lsps_pkg::SQRT_STAGES; k++) begin : g_stage
		logic                            prev_v;
		logic [lsps_pkg::REM_W-1:0]      prev_rem;
		logic [lsps_pkg::ROOT_W-1:0]     prev_root;
		logic [lsps_pkg::RADICAND_W-1:0] prev_rad;
		lsps_pkg::shade_side_t           prev_side;
		sq_step_t                        first;
		sq_step_t                        second;

		if (k == 0) begin : g_head
			assign prev_v    = in_valid;
			assign prev_rem  = '0;
			assign prev_root = '0;
			assign prev_rad  = in_radicand;
			assign prev_side = in_side;
		end else begin : g_body
			assign prev_v    = v_s[k-1];
			assign prev_rem  = rem_s[k-1];
			assign prev_root = root_s[k-1];
			assign prev_rad  = rad_s[k-1];
			assign prev_side = side_s[k-1];
		end

		if (k == LAST) begin : g_tail_en
			assign en[k] = !v_s[k] || out_ready;
		end else begin : g_mid_en
			assign en[k] = !v_s[k] || en[k+1];
		end

		assign first  = sqrt_step(prev_rem, prev_root,
				prev_rad[lsps_pkg::RADICAND_W-1 -: 2]);
		assign second = sqrt_step(first.rem, first.root,
				prev_rad[lsps_pkg::RADICAND_W-3 -: 2]);

		// Stage valid bit.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= prev_v;
			end
		end

		// Stage payload.
		always_ff @(posedge clk) begin
			if (en[k] && prev_v) begin
				rem_s[k]  <= second.rem;
				root_s[k] <= second.root;
				rad_s[k]  <= {prev_rad[lsps_pkg::RADICAND_W-5:0], 4'b0000};
				side_s[k] <= prev_side;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[LAST];
	assign out_root  = root_s[LAST];
	assign out_side  = side_s[LAST];

`ifndef SYNTHESIS
	// The final remainder never exceeds twice the root, or a root bit was missed.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, rem_s[LAST]} <= {2'b00, root_s[LAST], 1'b0}))
		else $error("square root remainder out of range");

	// A wholly empty pipeline always lets it take a new radicand.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && (v_s == {1'b0, {LAST{1'b0}}}) |-> in_ready)
		else $error("square root pipeline stalled while empty");

	// An accepted radicand lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s[0])
		else $error("accepted radicand lost at first stage");
`endif

endmodule
